[design/htw_pkg.sv]
package htw_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int POOL_SIZE  = 32;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int IDX_W      = $clog2(POOL_SIZE);
    localparam int LINK_W     = 6;
    localparam logic [LINK_W-1:0] NIL_LINK = 6'd63;
    localparam int TURNS_W    = 24;
    localparam logic [TURNS_W-1:0] TURNS_MAX = {TURNS_W{1'b1}};
    localparam logic [15:0] TICK_RESET = 16'd20;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] KIND_ADDED     = 2'd0;
    localparam logic [1:0] KIND_CANCELLED = 2'd1;
    localparam logic [1:0] KIND_EXPIRED   = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_ADD_HEAD,
        S_ADD_LINK,
        S_CANCEL,
        S_TICK_HEAD,
        S_TICK_VISIT,
        S_TICK_DONE
    } htw_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch input word
        logic div_start;
        logic add_read;    // read slot head for add
        logic add_link;    // file entry
        logic cancel_do;
        logic tick_read;   // read current head
        logic tick_visit;  // process entry at cursor
        logic tick_done;   // emit closing result and advance
    } htw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic cursor_nil;
        logic guard_end;
    } htw_stat_t;

endpackage

[design/htw_ctrl.sv]
module htw_ctrl
    import htw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] op,
    input  htw_stat_t  stat,
    output htw_cmd_t   cmd,
    output logic       busy
);

    htw_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (op)
                        OP_ADD:
                        begin
                            cmd.div_start = 1'b1;
                            state_next = S_DIV;
                        end
                        OP_CANCEL: state_next = S_CANCEL;
                        OP_TICK:   state_next = S_TICK_HEAD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_ADD_HEAD;
                end
            end
            S_ADD_HEAD:
            begin
                cmd.add_read = 1'b1;
                state_next = S_ADD_LINK;
            end
            S_ADD_LINK:
            begin
                cmd.add_link = 1'b1;
                state_next = S_IDLE;
            end
            S_CANCEL:
            begin
                cmd.cancel_do = 1'b1;
                state_next = S_IDLE;
            end
            S_TICK_HEAD:
            begin
                cmd.tick_read = 1'b1;
                state_next = S_TICK_VISIT;
            end
            S_TICK_VISIT:
            begin
                if (stat.cursor_nil || stat.guard_end)
                begin
                    state_next = S_TICK_DONE;
                end
                else
                begin
                    cmd.tick_visit = 1'b1;
                end
            end
            S_TICK_DONE:
            begin
                cmd.tick_done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[design/htw_dp.sv]
module htw_dp
    import htw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  htw_cmd_t           cmd,
    output htw_stat_t          stat,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  logic signed [31:0] delay_ms,
    input  logic signed [31:0] user_value,
    input  logic [4:0]         timer_id,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [4:0]         handle,
    output logic signed [31:0] fired_value,
    output logic [1:0]         status,
    output logic               last
);

    logic [15:0] tick_len_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [POOL_SIZE-1:0] busy_reg;
    logic [SLOT_COUNT-1:0] head_valid_reg;
    logic [LINK_W-1:0] head_mem [SLOT_COUNT];
    logic [LINK_W-1:0] fwd_mem [POOL_SIZE];
    logic [LINK_W-1:0] back_mem [POOL_SIZE];
    logic [SLOT_W-1:0] eslot_mem [POOL_SIZE];
    logic [TURNS_W-1:0] turns_mem [POOL_SIZE];
    logic [31:0] value_mem [POOL_SIZE];

    logic [31:0] delay_reg, value_reg;
    logic [4:0] id_reg;
    logic [31:0] rem_reg, quo_reg;
    logic [15:0] divisor_reg;
    logic [5:0] div_cnt_reg;
    logic div_run_reg;
    logic [LINK_W-1:0] head_rd_reg;
    logic [LINK_W-1:0] cursor_reg;
    logic [IDX_W:0] guard_reg;
    logic [SLOT_W-1:0] add_slot_reg;

    logic rv_reg, last_reg;
    logic [1:0] kind_reg, status_reg;
    logic [4:0] handle_reg;
    logic [31:0] fired_reg;

    logic [IDX_W-1:0] free_idx;
    logic free_any;
    logic [32:0] rem_sh;
    logic [31:0] ticks;
    logic [TURNS_W-1:0] turns;
    logic [SLOT_W-1:0] new_slot;
    logic [IDX_W-1:0] cur_e;
    logic [LINK_W-1:0] cur_prev, cur_next;
    logic id_ok;

    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign ticks = (quo_reg == 32'd0) ? 32'd1 : quo_reg;
    assign turns = (32'(ticks[31:SLOT_W]) > 32'(TURNS_MAX)) ? TURNS_MAX
                                                          : TURNS_W'(ticks[31:SLOT_W]);
    assign new_slot = cur_slot_reg + ticks[SLOT_W-1:0];
    assign cur_e = cursor_reg[IDX_W-1:0];
    assign cur_prev = back_mem[cur_e];
    assign cur_next = fwd_mem[cur_e];
    assign id_ok = busy_reg[id_reg];

    assign stat.div_done = !div_run_reg && !cmd.div_start;
    assign stat.cursor_nil = (cursor_reg >= LINK_W'(POOL_SIZE));
    assign stat.guard_end = (guard_reg >= (IDX_W+1)'(POOL_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_len_reg <= TICK_RESET;
            cur_slot_reg <= '0;
            busy_reg <= '0;
            head_valid_reg <= '0;
            div_run_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (cfg_we)
            begin
                tick_len_reg <= cfg_data;
            end
            if (cmd.div_start)
            begin
                div_run_reg <= !delay_ms[31];
            end
            else if (div_run_reg && div_cnt_reg == 6'd31)
            begin
                div_run_reg <= 1'b0;
            end
            if (cmd.add_link)
            begin
                rv_reg <= 1'b1;
                if (delay_reg[31] || !free_any)
                begin
                    // reject: nothing changes
                end
                else
                begin
                    busy_reg[free_idx] <= 1'b1;
                    head_valid_reg[add_slot_reg] <= 1'b1;
                end
            end
            if (cmd.cancel_do)
            begin
                rv_reg <= 1'b1;
                if (id_ok)
                begin
                    busy_reg[id_reg] <= 1'b0;
                end
            end
            if (cmd.tick_visit && turns_mem[cur_e] == '0)
            begin
                rv_reg <= 1'b1;
                busy_reg[cur_e] <= 1'b0;
            end
            if (cmd.tick_done)
            begin
                rv_reg <= 1'b1;
                cur_slot_reg <= cur_slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            delay_reg <= delay_ms;
            value_reg <= user_value;
            id_reg <= timer_id;
        end
        // restoring divide, one quotient bit per cycle
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= delay_ms;
            divisor_reg <= (tick_len_reg == 16'd0) ? 16'd1 : tick_len_reg;
            div_cnt_reg <= '0;
        end
        else if (div_run_reg)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (rem_sh >= {17'd0, divisor_reg})
            begin
                rem_reg <= 32'(rem_sh - {17'd0, divisor_reg});
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.add_read)
        begin
            add_slot_reg <= new_slot;
            head_rd_reg <= head_valid_reg[new_slot] ? head_mem[new_slot] : NIL_LINK;
        end
        if (cmd.add_link && !delay_reg[31] && free_any)
        begin
            eslot_mem[free_idx] <= add_slot_reg;
            turns_mem[free_idx] <= turns;
            value_mem[free_idx] <= value_reg;
            back_mem[free_idx] <= NIL_LINK;
            fwd_mem[free_idx] <= head_rd_reg;
            if (head_rd_reg < LINK_W'(POOL_SIZE))
            begin
                back_mem[head_rd_reg[IDX_W-1:0]] <= LINK_W'(free_idx);
            end
            head_mem[add_slot_reg] <= LINK_W'(free_idx);
        end
        if (cmd.add_link)
        begin
            kind_reg <= KIND_ADDED;
            fired_reg <= '0;
            last_reg <= 1'b1;
            if (delay_reg[31] || !free_any)
            begin
                handle_reg <= '0;
                status_reg <= ST_REJECT;
            end
            else
            begin
                handle_reg <= 5'(free_idx);
                status_reg <= ST_OK;
            end
        end
        if (cmd.cancel_do)
        begin
            kind_reg <= KIND_CANCELLED;
            handle_reg <= id_reg;
            fired_reg <= '0;
            last_reg <= 1'b1;
            status_reg <= id_ok ? ST_OK : ST_INACTIVE;
            if (id_ok)
            begin
                if (back_mem[id_reg] < LINK_W'(POOL_SIZE))
                begin
                    fwd_mem[back_mem[id_reg][IDX_W-1:0]] <= fwd_mem[id_reg];
                end
                else
                begin
                    head_mem[eslot_mem[id_reg]] <= fwd_mem[id_reg];
                end
                if (fwd_mem[id_reg] < LINK_W'(POOL_SIZE))
                begin
                    back_mem[fwd_mem[id_reg][IDX_W-1:0]] <= back_mem[id_reg];
                end
            end
        end
        if (cmd.tick_read)
        begin
            cursor_reg <= head_valid_reg[cur_slot_reg] ? head_mem[cur_slot_reg] : NIL_LINK;
            guard_reg <= '0;
        end
        if (cmd.tick_visit)
        begin
            cursor_reg <= cur_next;
            guard_reg <= guard_reg + 1'b1;
            if (turns_mem[cur_e] != '0)
            begin
                turns_mem[cur_e] <= turns_mem[cur_e] - 1'b1;
            end
            else
            begin
                kind_reg <= KIND_EXPIRED;
                handle_reg <= 5'(cur_e);
                fired_reg <= value_mem[cur_e];
                status_reg <= ST_OK;
                last_reg <= 1'b0;
                if (cur_prev < LINK_W'(POOL_SIZE))
                begin
                    fwd_mem[cur_prev[IDX_W-1:0]] <= cur_next;
                end
                else
                begin
                    head_mem[eslot_mem[cur_e]] <= cur_next;
                end
                if (cur_next < LINK_W'(POOL_SIZE))
                begin
                    back_mem[cur_next[IDX_W-1:0]] <= cur_prev;
                end
            end
        end
        if (cmd.tick_done)
        begin
            kind_reg <= KIND_TICK_DONE;
            handle_reg <= '0;
            fired_reg <= '0;
            status_reg <= ST_OK;
            last_reg <= 1'b1;
        end
    end

    assign result_valid = rv_reg;
    assign kind = kind_reg;
    assign handle = handle_reg;
    assign fired_value = fired_reg;
    assign status = status_reg;
    assign last = last_reg;

endmodule

[design/hashed_timing_wheel_core.sv]
// Hashed timing wheel: 256 slots over a pool of 32 timer entries.
// Issue a word by raising start with op and its fields while busy is low;
// it is taken at that clock edge. Ops: add (delay_ms, user_value),
// cancel (timer_id), tick. Op code 3 is taken and does nothing.
// Results appear on kind/handle/fired_value/status/last, each for one
// cycle with result_valid high; the receiver cannot stall, so take every
// word in the cycle it is shown. last marks the final result of a word.
// Add runs a serial divider by the tick length, then a slot head read
// and link; a negative delay skips the divide and is rejected. Cancel
// returns one word. A tick walks the current slot list one entry per
// cycle, emitting one expired word per timer that fires, then a closing
// word. The next word may be issued in the cycle that shows last.
// tick_length_we/tick_length_ms write the tick length; write it only while
// idle. Reset clears the wheel, frees all entries, sets the tick length to
// 20 ms and the current slot to 0; slot heads are tracked by valid bits.
module hashed_timing_wheel_core
    import htw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic signed [31:0] delay_ms,
    input  logic signed [31:0] user_value,
    input  logic [4:0]         timer_id,
    input  logic               tick_length_we,
    input  logic [15:0]        tick_length_ms,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [4:0]         handle,
    output logic signed [31:0] fired_value,
    output logic [1:0]         status,
    output logic               last
);

    htw_cmd_t  cmd;
    htw_stat_t stat;

    htw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    htw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (tick_length_we),
        .cfg_data     (tick_length_ms),
        .delay_ms     (delay_ms),
        .user_value   (user_value),
        .timer_id     (timer_id),
        .result_valid (result_valid),
        .kind         (kind),
        .handle       (handle),
        .fired_value  (fired_value),
        .status       (status),
        .last         (last)
    );

endmodule
